/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define BF_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define BF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/bf_pkg.sv */
// Shared constants, mode codes and control structs for the Blowfish unit.
// Depends on nothing; the other files but assert_macros.svh take names from here by scope.
`timescale 1ns / 1ps
`default_nettype none

package bf_pkg;

	localparam int ROUNDS      = 16;
	localparam int NUM_KEYS    = 18;
	localparam int SBOX_SIZE   = 256;
	localparam int SBOX_WORDS  = 'h400;
	localparam int NUM_BANKS   = SBOX_WORDS / SBOX_SIZE;
	localparam int TABLE_WORDS = NUM_KEYS + SBOX_WORDS;
	localparam int IDX_W       = 11;
	localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
	localparam int ENTRY_W     = $clog2(SBOX_SIZE);
	localparam int BANK_W      = $clog2(NUM_BANKS);
	localparam int RND_W       = (ROUNDS > 2) ? $clog2(ROUNDS) : 1;
	localparam int WORD_W      = 32;

	localparam logic [1:0] MODE_LOAD  = 2'd0;
	localparam logic [1:0] MODE_ENC   = 2'd1;
	localparam logic [1:0] MODE_DEC   = 2'd2;
	localparam logic [1:0] MODE_REKEY = 2'd3;

	typedef struct packed {
		logic                 we;
		logic [KEY_IDX_W-1:0] widx;
		logic [WORD_W-1:0]    wdata;
		logic                 rekey;
		logic [2*WORD_W-1:0]  rekey_bytes;
		logic [KEY_IDX_W-1:0] ridx;
	} key_ctl_t;

	typedef struct packed {
		logic [WORD_W-1:0] round_key;
		logic [WORD_W-1:0] key_0;
		logic [WORD_W-1:0] key_1;
		logic [WORD_W-1:0] key_r;
		logic [WORD_W-1:0] key_r1;
	} key_taps_t;

endpackage

`default_nettype wire

/* hw/rtl/bf_cmd_if.sv */
// Command channel: valid/ready handshake with the mode and operand fields.
// Depends on bf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bf_cmd_if;
	logic                      valid;
	logic                      ready;
	logic [1:0]                mode;
	logic [bf_pkg::IDX_W-1:0]  table_index;
	logic [bf_pkg::WORD_W-1:0] table_word;
	logic [bf_pkg::WORD_W-1:0] block_left;
	logic [bf_pkg::WORD_W-1:0] block_right;
	logic [63:0]               rekey_bytes;

	modport source (output valid, mode, table_index, table_word, block_left, block_right,
		rekey_bytes, input ready);
	modport sink (input valid, mode, table_index, table_word, block_left, block_right,
		rekey_bytes, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bf_res_if.sv */
// Result channel: valid/ready handshake carrying one transformed block.
// Depends on bf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bf_res_if;
	logic                      valid;
	logic                      ready;
	logic [bf_pkg::WORD_W-1:0] result_left;
	logic [bf_pkg::WORD_W-1:0] result_right;

	modport source (output valid, result_left, result_right, input ready);
	modport sink (input valid, result_left, result_right, output ready);
endinterface

`default_nettype wire

/* hw/rtl/bf_sbox_ram.sv */
// One S-box bank: 256 x 32 synchronous RAM, one write and one registered read port.
// Depends on bf_pkg for depth and width.
`timescale 1ns / 1ps
`default_nettype none

module bf_sbox_ram (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [bf_pkg::ENTRY_W-1:0] waddr,
	input  wire logic [bf_pkg::WORD_W-1:0]  wdata,
	input  wire logic [bf_pkg::ENTRY_W-1:0] raddr,
	output      logic [bf_pkg::WORD_W-1:0]  rdata
);

	logic [bf_pkg::WORD_W-1:0] mem_q [bf_pkg::SBOX_SIZE];
	logic [bf_pkg::WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/bf_key_file.sv */
// Round-key register file: 18 words, one indexed read and fixed whitening taps.
// Depends on bf_pkg for key_ctl_t and key_taps_t.
`timescale 1ns / 1ps
`default_nettype none

module bf_key_file (
	input  wire logic              clk,
	input  wire bf_pkg::key_ctl_t  ctl,
	output      bf_pkg::key_taps_t taps
);

	logic [bf_pkg::WORD_W-1:0] keys_q [bf_pkg::NUM_KEYS];

	// Rekey folds the key bytes into every word at once; even words take the high half.
	always_ff @(posedge clk) begin
		if (ctl.rekey) begin
			for (int j = 0; j < bf_pkg::NUM_KEYS; j++) begin
				keys_q[j] <= keys_q[j] ^ ((j % 2 == 1) ? ctl.rekey_bytes[bf_pkg::WORD_W-1:0]
					: ctl.rekey_bytes[2*bf_pkg::WORD_W-1:bf_pkg::WORD_W]);
			end
		end else if (ctl.we) begin
			keys_q[ctl.widx] <= ctl.wdata;
		end
	end

	assign taps.round_key = keys_q[ctl.ridx];
	assign taps.key_0     = keys_q[0];
	assign taps.key_1     = keys_q[1];
	assign taps.key_r     = keys_q[bf_pkg::ROUNDS];
	assign taps.key_r1    = keys_q[bf_pkg::ROUNDS+1];

endmodule

`default_nettype wire

/* hw/rtl/blowfish_cipher_with_rekey_unit.sv */
// Top level of the Blowfish cipher unit with in-place rekey.
// Depends on bf_pkg, bf_cmd_if, bf_res_if, bf_sbox_ram and bf_key_file.
`timescale 1ns / 1ps
`default_nettype none

// Blowfish 64-bit block cipher with its own key table. Commands arrive on cmd and
// are taken one at a time: a load writes one table word (0..17 round keys, 18..1041
// S-box words, higher indexes ignored) and the unit stays idle; an encrypt or decrypt
// runs its rounds, waits in FIN until the output register is free, and leaves its
// block in that register on result, so the next command is taken while the block
// waits to be collected. The round loop sets the pace: the four S-boxes live in four
// synchronous RAM banks, one read each per round, and the registered RAM read closes
// each round. A rekey folds the key bytes into the round keys and then runs 521
// chained encryptions, each writing two table words through the single write port.
// Table words read before being loaded hold whatever the RAM held.
module blowfish_cipher_with_rekey_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	bf_cmd_if.sink    cmd,
	bf_res_if.source  result
);

	localparam int W = bf_pkg::WORD_W;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_RND   = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_WR    = 3'd4;

	// Control state.
	logic [2:0]               state_q;
	logic                     dec_q;
	logic                     rekey_q;
	logic [bf_pkg::RND_W-1:0] rnd_q;
	logic [bf_pkg::IDX_W-1:0] widx_q;
	logic                     out_valid_q;

	// Datapath: a_q/b_q hold the block halves, x_q is the word just sent to the
	// S-boxes, y_q the word it is XORed into once the lookups return.
	logic [W-1:0] a_q, b_q, x_q, y_q;
	logic [W-1:0] out_l_q, out_r_q;

	logic accept;
	logic last_rnd;
	logic out_free;

	bf_pkg::key_ctl_t  key_ctl;
	bf_pkg::key_taps_t key_taps;

	logic [bf_pkg::KEY_IDX_W-1:0] step_k;
	logic [W-1:0] sbox_rd [bf_pkg::NUM_BANKS];
	logic [W-1:0] f_val, new_a, c_src, c_val;
	logic [W-1:0] res_l, res_r;

	// Table write request, shared by loads and rekey refill.
	logic                       tw_en;
	logic [bf_pkg::IDX_W-1:0]   tw_idx;
	logic [W-1:0]               tw_data;
	logic [bf_pkg::IDX_W-1:0]   sbox_off;
	logic                       sbox_we;
	logic [bf_pkg::BANK_W-1:0]  sbox_bank;

	assign cmd.ready = (state_q == ST_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign last_rnd  = (rnd_q == bf_pkg::RND_W'(bf_pkg::ROUNDS - 1));
	assign out_free  = !out_valid_q || result.ready;

	// Round key for the lookup being issued: the first round in START, the next one
	// in RND. Decrypt walks the keys from the top down.
	assign step_k = (state_q == ST_START) ? '0
		: bf_pkg::KEY_IDX_W'(rnd_q) + bf_pkg::KEY_IDX_W'(1);
	assign key_ctl.ridx = dec_q ? bf_pkg::KEY_IDX_W'(bf_pkg::ROUNDS + 1) - step_k : step_k;

	// Round function from the registered S-box reads, then the next lookup address
	// straight out of it, so one round closes per cycle.
	assign f_val = sbox_rd[3] + (sbox_rd[2] ^ (sbox_rd[1] + sbox_rd[0]));
	assign new_a = y_q ^ f_val;
	assign c_src = (state_q == ST_START) ? a_q : new_a;
	assign c_val = key_taps.round_key ^ c_src;

	// Output whitening.
	assign res_l = dec_q ? (b_q ^ key_taps.key_0) : (b_q ^ key_taps.key_r1);
	assign res_r = dec_q ? (a_q ^ key_taps.key_1) : (a_q ^ key_taps.key_r);

	always_comb begin
		tw_en   = 1'b0;
		tw_idx  = widx_q;
		tw_data = res_l;
		if (accept && cmd.mode == bf_pkg::MODE_LOAD) begin
			tw_en   = 1'b1;
			tw_idx  = cmd.table_index;
			tw_data = cmd.table_word;
		end else if (state_q == ST_FIN && rekey_q) begin
			tw_en   = 1'b1;
			tw_idx  = widx_q;
			tw_data = res_l;
		end else if (state_q == ST_WR) begin
			tw_en   = 1'b1;
			tw_idx  = widx_q + bf_pkg::IDX_W'(1);
			tw_data = b_q;
		end
	end

	// Decode the flat table index into round key or S-box bank and entry.
	assign sbox_off  = tw_idx - bf_pkg::IDX_W'(bf_pkg::NUM_KEYS);
	assign sbox_bank = sbox_off[bf_pkg::ENTRY_W+bf_pkg::BANK_W-1:bf_pkg::ENTRY_W];
	assign sbox_we   = tw_en && (tw_idx >= bf_pkg::IDX_W'(bf_pkg::NUM_KEYS))
		&& (tw_idx < bf_pkg::IDX_W'(bf_pkg::TABLE_WORDS));

	assign key_ctl.we          = tw_en && (tw_idx < bf_pkg::IDX_W'(bf_pkg::NUM_KEYS));
	assign key_ctl.widx        = tw_idx[bf_pkg::KEY_IDX_W-1:0];
	assign key_ctl.wdata       = tw_data;
	assign key_ctl.rekey       = accept && (cmd.mode == bf_pkg::MODE_REKEY);
	assign key_ctl.rekey_bytes = cmd.rekey_bytes;

	bf_key_file u_keys (
		.clk  (clk),
		.ctl  (key_ctl),
		.taps (key_taps)
	);

	// Bank 0 is indexed by the top byte of the lookup word, bank 3 by the bottom.
	for (genvar g = 0; g < bf_pkg::NUM_BANKS; g++) begin : g_bank
		bf_sbox_ram u_ram (
			.clk   (clk),
			.we    (sbox_we && (sbox_bank == bf_pkg::BANK_W'(g))),
			.waddr (sbox_off[bf_pkg::ENTRY_W-1:0]),
			.wdata (tw_data),
			.raddr (c_val[(bf_pkg::NUM_BANKS-1-g)*bf_pkg::ENTRY_W +: bf_pkg::ENTRY_W]),
			.rdata (sbox_rd[g])
		);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dec_q       <= 1'b0;
			rekey_q     <= 1'b0;
			rnd_q       <= '0;
			widx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FIN && !rekey_q && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.mode)
							bf_pkg::MODE_ENC: begin
								dec_q   <= 1'b0;
								rekey_q <= 1'b0;
								state_q <= ST_START;
							end
							bf_pkg::MODE_DEC: begin
								dec_q   <= 1'b1;
								rekey_q <= 1'b0;
								state_q <= ST_START;
							end
							bf_pkg::MODE_REKEY: begin
								dec_q   <= 1'b0;
								rekey_q <= 1'b1;
								widx_q  <= '0;
								state_q <= ST_START;
							end
							default: begin
								// load: the write lands at this edge, stay idle
							end
						endcase
					end
				end
				ST_START: begin
					rnd_q   <= '0;
					state_q <= ST_RND;
				end
				ST_RND: begin
					if (last_rnd) begin
						state_q <= ST_FIN;
					end else begin
						rnd_q <= rnd_q + bf_pkg::RND_W'(1);
					end
				end
				ST_FIN: begin
					// hold a cipher block here until the output register frees up; a rekey goes on to WR
					if (rekey_q) begin
						state_q <= ST_WR;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WR: begin
					if (widx_q == bf_pkg::IDX_W'(bf_pkg::TABLE_WORDS - 2)) begin
						rekey_q <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						widx_q  <= widx_q + bf_pkg::IDX_W'(2);
						state_q <= ST_START;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Block datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd.mode == bf_pkg::MODE_REKEY) begin
						// refill chain starts from an all-zero block
						a_q <= '0;
						b_q <= '0;
					end else begin
						a_q <= cmd.block_left;
						b_q <= cmd.block_right;
					end
				end
			end
			ST_START: begin
				x_q <= c_val;
				y_q <= b_q;
			end
			ST_RND: begin
				if (last_rnd) begin
					a_q <= new_a;
					b_q <= x_q;
				end else begin
					x_q <= c_val;
					y_q <= x_q;
				end
			end
			ST_FIN: begin
				if (rekey_q) begin
					// chain the block into the next encryption; right half goes out in WR
					a_q <= res_l;
					b_q <= res_r;
				end else if (out_free) begin
					out_l_q <= res_l;
					out_r_q <= res_r;
				end
			end
			default: begin
			end
		endcase
	end

	assign result.valid        = out_valid_q;
	assign result.result_left  = out_l_q;
	assign result.result_right = out_r_q;

endmodule

`default_nettype wire

/* hw/rtl/bf_checker.sv */
// Port-level checks for the Blowfish unit, bound onto the top level.
// Depends on bf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bf_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      cmd_valid,
	input wire logic                      cmd_ready,
	input wire logic [1:0]                cmd_mode,
	input wire logic                      res_valid,
	input wire logic                      res_ready,
	input wire logic [bf_pkg::WORD_W-1:0] res_left,
	input wire logic [bf_pkg::WORD_W-1:0] res_right
);

	logic cipher_xfer;
	logic load_xfer;

	assign cipher_xfer = cmd_valid && cmd_ready
		&& (cmd_mode == bf_pkg::MODE_ENC || cmd_mode == bf_pkg::MODE_DEC);
	assign load_xfer = cmd_valid && cmd_ready && (cmd_mode == bf_pkg::MODE_LOAD);

	`BF_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")
	`BF_ASSERT(a_res_stable, clk, arst_n, !($past(res_valid && !res_ready)) || ($stable(res_left) && $stable(res_right)), "result payload changed while stalled")
	`BF_ASSERT_NEXT(a_cipher_busy, clk, arst_n, cipher_xfer, !cmd_ready, "command taken during a block transform")
	`BF_ASSERT_NEXT(a_load_single, clk, arst_n, load_xfer, cmd_ready, "load did not finish in one cycle")

endmodule

bind blowfish_cipher_with_rekey_unit bf_checker u_bf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.cmd_valid (cmd.valid),
	.cmd_ready (cmd.ready),
	.cmd_mode  (cmd.mode),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_left  (result.result_left),
	.res_right (result.result_right)
);

`default_nettype wire

/* verif/tb.sv */
// Self-checking bench for blowfish_cipher_with_rekey_unit: table loads, encrypt, decrypt, rekey.
// Depends on bf_pkg, bf_cmd_if, bf_res_if and the unit itself; expected blocks come from
// a cipher model kept in the bench and are compared in order with what the unit returns.
`timescale 1ns / 1ps

module tb;

	localparam int CLK_PERIOD   = 12;
	localparam int N_KEYS       = 18;
	localparam int N_WORDS      = 1042;
	localparam int N_RANDOM     = 30;
	localparam int MAX_REKEYS   = 24;
	localparam int ENC_CYCLES   = bf_pkg::ROUNDS + 3;
	localparam int REKEY_CYCLES = 1 + (N_WORDS / 2) * ENC_CYCLES;
	// Slowest legal run: every item with full gaps and stalls, every rekey at full length,
	// then taken four times over.
	localparam longint LIMIT_NS = 64'd12 * 64'd4 *
		(64'd2200 * (ENC_CYCLES + 24) + 64'd28 * REKEY_CYCLES);

	typedef struct packed {
		logic [1:0]  mode;
		logic [10:0] table_index;
		logic [31:0] table_word;
		logic [31:0] block_left;
		logic [31:0] block_right;
		logic [63:0] rekey_bytes;
	} cmd_item_t;

	typedef struct packed {
		logic [31:0] left;
		logic [31:0] right;
	} block_t;

	logic clk = 1'b0;
	logic arst_n;

	bf_cmd_if cmd_ch ();
	bf_res_if res_ch ();

	blowfish_cipher_with_rekey_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.result (res_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Cipher model state: round keys and the four S-boxes packed back to back.
	logic [31:0] pkey [0:N_KEYS-1];
	logic [31:0] sbox_mem [0:1023];

	cmd_item_t pending_cmds[$];
	block_t    expected_blocks[$];
	cmd_item_t cur_cmd;
	block_t    want_blk;
	int        n_accepted = 0;
	int        n_total = 0;
	int        n_errors = 0;
	int        send_gap;
	int        recv_stall;
	bit        cmd_calm;
	bit        res_calm;

	// F function: S-box lookups on the four bytes, most significant byte into S-box 0.
	function automatic logic [31:0] round_mix(input logic [31:0] x);
		return sbox_mem[{2'd3, x[7:0]}] +
			(sbox_mem[{2'd2, x[15:8]}] ^ (sbox_mem[{2'd1, x[23:16]}] + sbox_mem[{2'd0, x[31:24]}]));
	endfunction

	function automatic block_t encipher(input block_t b);
		logic [31:0] a;
		logic [31:0] d;
		logic [31:0] c;
		int i;
		a = b.left;
		d = b.right;
		for (i = 0; i < bf_pkg::ROUNDS; i++) begin
			c = pkey[i] ^ a;
			a = d ^ round_mix(c);
			d = c;
		end
		return '{left: d ^ pkey[bf_pkg::ROUNDS + 1], right: a ^ pkey[bf_pkg::ROUNDS]};
	endfunction

	// Same rounds with the keys walked from the top down to key 2.
	function automatic block_t decipher(input block_t b);
		logic [31:0] a;
		logic [31:0] d;
		logic [31:0] c;
		int i;
		a = b.left;
		d = b.right;
		for (i = bf_pkg::ROUNDS + 1; i > 1; i--) begin
			c = pkey[i] ^ a;
			a = d ^ round_mix(c);
			d = c;
		end
		return '{left: d ^ pkey[0], right: a ^ pkey[1]};
	endfunction

	// Indexes past the end of the table are dropped.
	task automatic table_write(input int idx, input logic [31:0] w);
		if (idx < N_KEYS) begin
			pkey[idx] = w;
		end else if (idx < N_WORDS) begin
			sbox_mem[idx - N_KEYS] = w;
		end
	endtask

	// Fold the key into the round keys, then rebuild the table from a zero block chain.
	task automatic rekey_table(input logic [63:0] kb);
		block_t chain;
		int i;
		for (i = 0; i < N_KEYS; i++) begin
			pkey[i] = pkey[i] ^ ((i % 2 == 1) ? kb[31:0] : kb[63:32]);
		end
		chain = '0;
		for (i = 0; i < N_WORDS; i += 2) begin
			chain = encipher(chain);
			table_write(i, chain.left);
			table_write(i + 1, chain.right);
		end
	endtask

	// Advance the model by one accepted command; queue the block it should return.
	task automatic apply_cmd(input cmd_item_t it);
		case (it.mode)
			bf_pkg::MODE_LOAD: begin
				table_write(int'(it.table_index), it.table_word);
			end
			bf_pkg::MODE_ENC: begin
				expected_blocks.push_back(encipher('{left: it.block_left, right: it.block_right}));
			end
			bf_pkg::MODE_DEC: begin
				expected_blocks.push_back(decipher('{left: it.block_left, right: it.block_right}));
			end
			default: begin
				rekey_table(it.rekey_bytes);
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		n_errors++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// Block halves lean on the all-zero and all-one corners now and then.
	function automatic logic [31:0] rand_half();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Every field random, mode fixed; unused fields stay random as noise.
	function automatic cmd_item_t rand_cmd(input logic [1:0] m);
		cmd_item_t it;
		it.mode        = m;
		it.table_index = 11'($urandom_range(0, N_WORDS - 1));
		it.table_word  = $urandom;
		it.block_left  = rand_half();
		it.block_right = rand_half();
		it.rekey_bytes = {$urandom, $urandom};
		return it;
	endfunction

	// Command driver: present the next pending command once the bus is free and the
	// drawn gap has run out; hold the payload steady while the unit is busy.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_ch.valid       <= 1'b0;
			cmd_ch.mode        <= bf_pkg::MODE_LOAD;
			cmd_ch.table_index <= '0;
			cmd_ch.table_word  <= '0;
			cmd_ch.block_left  <= '0;
			cmd_ch.block_right <= '0;
			cmd_ch.rekey_bytes <= '0;
			send_gap = 0;
			cmd_calm = 1'b0;
		end else begin
			if (cmd_ch.valid && cmd_ch.ready) begin
				apply_cmd(cur_cmd);
				n_accepted++;
				// Switch now and then between bursts with no gaps and gappy traffic.
				if ($urandom_range(0, 39) == 0) begin
					cmd_calm = !cmd_calm;
				end
				send_gap = cmd_calm ? 0 : $urandom_range(0, 10);
			end
			if (!cmd_ch.valid || cmd_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					cur_cmd = pending_cmds.pop_front();
					cmd_ch.mode        <= cur_cmd.mode;
					cmd_ch.table_index <= cur_cmd.table_index;
					cmd_ch.table_word  <= cur_cmd.table_word;
					cmd_ch.block_left  <= cur_cmd.block_left;
					cmd_ch.block_right <= cur_cmd.block_right;
					cmd_ch.rekey_bytes <= cur_cmd.rekey_bytes;
					cmd_ch.valid       <= 1'b1;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each transfer against the oldest expected block, then hold
	// ready low for a drawn number of cycles in which a result is waiting.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			recv_stall = 0;
			res_calm = 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_blocks.size() == 0) begin
					report_mismatch($sformatf("block %h_%h with none expected",
						res_ch.result_left, res_ch.result_right));
				end else begin
					want_blk = expected_blocks.pop_front();
					if (res_ch.result_left !== want_blk.left) begin
						report_mismatch($sformatf("result_left %h, expected %h",
							res_ch.result_left, want_blk.left));
					end
					if (res_ch.result_right !== want_blk.right) begin
						report_mismatch($sformatf("result_right %h, expected %h",
							res_ch.result_right, want_blk.right));
					end
				end
				if ($urandom_range(0, 39) == 0) begin
					res_calm = !res_calm;
				end
				recv_stall = res_calm ? 0 : $urandom_range(0, 10);
				res_ch.ready <= (recv_stall == 0);
			end else if (res_ch.valid && recv_stall > 0) begin
				recv_stall--;
				res_ch.ready <= (recv_stall == 0);
			end else begin
				res_ch.ready <= (recv_stall == 0);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		cmd_item_t it;
		int i;
		int sel;
		int n_rekey;

		arst_n = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.mode        = bf_pkg::MODE_LOAD;
		cmd_ch.table_index = '0;
		cmd_ch.table_word  = '0;
		cmd_ch.block_left  = '0;
		cmd_ch.block_right = '0;
		cmd_ch.rekey_bytes = '0;
		res_ch.ready       = 1'b0;

		// Fill the whole table first: nothing may read a word that was never written.
		for (i = 0; i < N_WORDS; i++) begin
			it = rand_cmd(bf_pkg::MODE_LOAD);
			it.table_index = 11'(i);
			pending_cmds.push_back(it);
		end

		// Directed corners: block extremes, table ends, ignored indexes, rekey extremes.
		it = rand_cmd(bf_pkg::MODE_ENC);
		it.block_left = '0;
		it.block_right = '0;
		pending_cmds.push_back(it);
		it.block_left = '1;
		it.block_right = '1;
		pending_cmds.push_back(it);
		it = rand_cmd(bf_pkg::MODE_DEC);
		it.block_left = '0;
		it.block_right = '0;
		pending_cmds.push_back(it);
		it.block_left = '1;
		it.block_right = '1;
		pending_cmds.push_back(it);
		it = rand_cmd(bf_pkg::MODE_LOAD);
		it.table_index = '0;
		it.table_word = '0;
		pending_cmds.push_back(it);
		it.table_index = 11'(N_KEYS - 1);
		it.table_word = '1;
		pending_cmds.push_back(it);
		it.table_index = 11'(N_KEYS);
		pending_cmds.push_back(it);
		it.table_index = 11'(N_WORDS - 1);
		it.table_word = '0;
		pending_cmds.push_back(it);
		it = rand_cmd(bf_pkg::MODE_LOAD);
		it.table_index = 11'(N_WORDS);
		pending_cmds.push_back(it);
		it = rand_cmd(bf_pkg::MODE_LOAD);
		it.table_index = 11'h7ff;
		pending_cmds.push_back(it);
		pending_cmds.push_back(rand_cmd(bf_pkg::MODE_ENC));
		pending_cmds.push_back(rand_cmd(bf_pkg::MODE_DEC));
		it = rand_cmd(bf_pkg::MODE_REKEY);
		it.rekey_bytes = '0;
		pending_cmds.push_back(it);
		it = rand_cmd(bf_pkg::MODE_ENC);
		it.block_left = '0;
		it.block_right = '0;
		pending_cmds.push_back(it);
		it = rand_cmd(bf_pkg::MODE_REKEY);
		it.rekey_bytes = '1;
		pending_cmds.push_back(it);
		it = rand_cmd(bf_pkg::MODE_ENC);
		it.block_left = '1;
		it.block_right = '0;
		pending_cmds.push_back(it);
		it = rand_cmd(bf_pkg::MODE_DEC);
		it.block_left = '0;
		it.block_right = '1;
		pending_cmds.push_back(it);
		pending_cmds.push_back(rand_cmd(bf_pkg::MODE_REKEY));
		pending_cmds.push_back(rand_cmd(bf_pkg::MODE_ENC));

		// Random mix; rekeys are rare and capped since each one runs a long table refill.
		n_rekey = 0;
		for (i = 0; i < N_RANDOM; i++) begin
			sel = $urandom_range(0, 99);
			if (sel < 45) begin
				it = rand_cmd(bf_pkg::MODE_ENC);
			end else if (sel < 75) begin
				it = rand_cmd(bf_pkg::MODE_DEC);
			end else if (sel < 97) begin
				it = rand_cmd(bf_pkg::MODE_LOAD);
				if ($urandom_range(0, 7) == 0) begin
					it.table_index = 11'($urandom_range(N_WORDS, 2047));
				end
			end else if (n_rekey < MAX_REKEYS) begin
				it = rand_cmd(bf_pkg::MODE_REKEY);
				n_rekey++;
			end else begin
				it = rand_cmd(bf_pkg::MODE_ENC);
			end
			pending_cmds.push_back(it);
		end
		n_total = pending_cmds.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted < n_total) @(posedge clk);
		while (expected_blocks.size() > 0) @(posedge clk);
		// Let a trailing rekey run out so any stray result still shows up.
		repeat (REKEY_CYCLES + 32) @(posedge clk);

		if (n_errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(LIMIT_NS);
		$display("status: fail");
		$finish;
	end

endmodule
